// ----- hdl/tgfw_pkg.sv -----
// tgfw_pkg: shared types and constants for the text glyph framebuffer writer.
// No dependencies.

package tgfw_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_PUT  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    localparam int PATTERN_W = 25;
    localparam int CODE_W    = 8;
    localparam int COORD_W   = 7;
    localparam int CURSOR_W  = 8;
    localparam int CELL_W    = 2;

    localparam logic [CODE_W-1:0]   CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0]   CODE_SKIP    = 8'd96;
    localparam logic [CURSOR_W-1:0] CURSOR_MAX   = 8'd255;

    localparam logic [CELL_W-1:0] CELL_NONE  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_BLANK = 2'd1;
    localparam logic [CELL_W-1:0] CELL_LIT   = 2'd2;

    // reciprocal multiply used to split a frame row into text line and sub-row
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_PROD_W = 25;

endpackage

// ----- hdl/tgfw_store.sv -----
// tgfw_store: single write port, single registered read port memory with a
// per-entry valid bit; unwritten entries read as zero, a same-cycle write is
// forwarded to the read. Depends on nothing.

module tgfw_store #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 25,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_in_range;

    assign rd_in_range = {1'b0, rd_addr} < (AW+1)'(DEPTH);
    assign rd_data     = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (rd_in_range && valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

// ----- hdl/tgfw_line_edit.sv -----
// tgfw_line_edit: merges one glyph into a text-line word at a given column and
// picks one cell out of the same word. Depends on tgfw_pkg.

module tgfw_line_edit
    import tgfw_pkg::*;
#(
    parameter int GLYPH_SIZE = 5,
    parameter int FRAME_COLS = 80,
    parameter int SW         = 3,
    parameter int CW         = 7
) (
    input  logic [CELL_W*GLYPH_SIZE*FRAME_COLS-1:0] line_word,
    input  logic [PATTERN_W-1:0]                    pattern,
    input  logic [CURSOR_W-1:0]                     col0,
    input  logic                                    opaque,
    input  logic [SW-1:0]                           sub,
    input  logic [CW-1:0]                           col,
    output logic [CELL_W*GLYPH_SIZE*FRAME_COLS-1:0] line_next,
    output logic [CELL_W-1:0]                       cell_rd
);

    localparam int PW = GLYPH_SIZE * GLYPH_SIZE;
    localparam int HW = $clog2(GLYPH_SIZE);
    localparam int IW = $clog2(GLYPH_SIZE * FRAME_COLS);

    logic [PW-1:0]         pat_ext;
    logic [CURSOR_W:0]     dh [FRAME_COLS];
    logic [FRAME_COLS-1:0] hit;
    logic [IW-1:0]         cell_idx;

    assign pat_ext = PW'(pattern);

    always_comb
    begin
        for (int c = 0; c < FRAME_COLS; c++)
        begin
            dh[c]  = (CURSOR_W+1)'(c) - {1'b0, col0};
            hit[c] = dh[c] < (CURSOR_W+1)'(GLYPH_SIZE);
        end
    end

    always_comb
    begin
        line_next = line_word;
        for (int v = 0; v < GLYPH_SIZE; v++)
        begin
            for (int c = 0; c < FRAME_COLS; c++)
            begin
                if (hit[c])
                begin
                    if (pat_ext[v*GLYPH_SIZE + int'(dh[c][HW-1:0])])
                    begin
                        line_next[(v*FRAME_COLS + c)*CELL_W +: CELL_W] = CELL_LIT;
                    end
                    else if (opaque)
                    begin
                        line_next[(v*FRAME_COLS + c)*CELL_W +: CELL_W] = CELL_BLANK;
                    end
                end
            end
        end
    end

    assign cell_idx = IW'(sub) * IW'(FRAME_COLS) + IW'(col);
    assign cell_rd  = line_word[{cell_idx, 1'b0} +: CELL_W];

endmodule

// ----- hdl/text_glyph_framebuffer_writer.sv -----
// Takes one request per clock while responses are taken: glyph loads,
// character puts and cell reads. A request is registered in stage 1 and
// then in the response register; a response stall holds both. The framebuffer
// is held as one word per text line (GLYPH_SIZE pixel rows), so a character
// costs a single read-modify-write of that word; per-line and per-glyph valid
// bits give the cleared state straight after reset, with no clearing pass.
// Depends on tgfw_pkg, tgfw_store and tgfw_line_edit.

module text_glyph_framebuffer_writer
    import tgfw_pkg::*;
#(
    parameter int GLYPH_SIZE  = 5,
    parameter int GLYPH_COUNT = 128,
    parameter int FRAME_ROWS  = 80,
    parameter int FRAME_COLS  = 80
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           action,
    input  logic [COORD_W-1:0]   glyph_index,
    input  logic [PATTERN_W-1:0] glyph_pattern,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [COORD_W-1:0]   view_row,
    input  logic [COORD_W-1:0]   view_col,
    input  logic [COORD_W-1:0]   row_offset,
    input  logic [COORD_W-1:0]   col_offset,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [CELL_W-1:0]    cell_code,
    output logic [CURSOR_W-1:0]  cursor_row,
    output logic [CURSOR_W-1:0]  cursor_col,
    output logic                 status
);

    localparam int LINES  = (FRAME_ROWS + GLYPH_SIZE - 1) / GLYPH_SIZE;
    localparam int LA     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LW     = $clog2(LINES + 1);
    localparam int GA     = $clog2(GLYPH_COUNT);
    localparam int SW     = $clog2(GLYPH_SIZE);
    localparam int CW     = $clog2(FRAME_COLS);
    localparam int LINE_W = CELL_W * GLYPH_SIZE * FRAME_COLS;
    localparam int RECIP  = (2**RECIP_SHIFT + GLYPH_SIZE - 1) / GLYPH_SIZE;

    // configuration and cursor state
    logic                opaque_reg;
    logic [CURSOR_W-1:0] row_reg, row_next;
    logic [CURSOR_W-1:0] col_reg, col_next;
    logic [LW-1:0]       line_reg, line_next;

    // decode
    logic accept;
    logic is_load, is_put, is_read;
    logic put_newline, put_skip, put_bad, put_draw, draw_en;
    logic load_en;
    logic [CURSOR_W:0] row_sum, col_sum;

    // read address
    logic [CURSOR_W-1:0]     rs, cs;
    logic                    read_ok;
    logic [RECIP_PROD_W-1:0] rs_prod;
    logic [CURSOR_W-1:0]     rs_line, rs_sub;

    // stage 1
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_draw_reg;
    logic                s1_read_ok_reg;
    logic [LA-1:0]       s1_line_reg;
    logic [SW-1:0]       s1_sub_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [CURSOR_W-1:0] s1_col0_reg;
    logic [CURSOR_W-1:0] s1_row_out_reg, s1_col_out_reg;
    logic                s1_status_reg;
    logic                s1_advance;

    logic [LA-1:0]          frame_rd_addr;
    logic [LINE_W-1:0]      frame_rd_data, frame_wr_data;
    logic [PATTERN_W-1:0]   glyph_rd_data;
    logic [CELL_W-1:0]      edit_cell;

    // response register
    logic                rsp_valid_reg;
    logic [CELL_W-1:0]   cell_code_reg;
    logic [CURSOR_W-1:0] cursor_row_reg, cursor_col_reg;
    logic                status_reg;

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign accept     = req_valid && !req_stall;

    assign is_load = action == ACT_LOAD;
    assign is_put  = action == ACT_PUT;
    assign is_read = action == ACT_READ;

    assign put_newline = is_put && (char_code == CODE_NEWLINE);
    assign put_skip    = is_put && (char_code == CODE_SKIP);
    assign put_bad     = is_put && !put_newline && !put_skip &&
                         (char_code[CODE_W-1] ||
                          ({1'b0, char_code} >= (CODE_W+1)'(GLYPH_COUNT)));
    assign put_draw    = is_put && !put_newline && !put_skip && !put_bad;
    assign draw_en     = put_draw && (line_reg < LW'(LINES));
    assign load_en     = accept && is_load &&
                         ({2'b0, glyph_index} < (COORD_W+2)'(GLYPH_COUNT));

    assign row_sum = {1'b0, row_reg} + (CURSOR_W+1)'(GLYPH_SIZE);
    assign col_sum = {1'b0, col_reg} + (CURSOR_W+1)'(GLYPH_SIZE);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        line_next = line_reg;
        if (put_newline)
        begin
            row_next  = row_sum[CURSOR_W] ? CURSOR_MAX : row_sum[CURSOR_W-1:0];
            col_next  = '0;
            line_next = (line_reg == LW'(LINES)) ? line_reg : line_reg + LW'(1);
        end
        else if (put_draw)
        begin
            col_next = col_sum[CURSOR_W] ? CURSOR_MAX : col_sum[CURSOR_W-1:0];
        end
    end

    // wrap once and split the row into text line and sub-row
    always_comb
    begin
        rs = {1'b0, view_row} + {1'b0, row_offset};
        cs = {1'b0, view_col} + {1'b0, col_offset};
        if (rs >= CURSOR_W'(FRAME_ROWS))
        begin
            rs = rs - CURSOR_W'(FRAME_ROWS);
        end
        if (cs >= CURSOR_W'(FRAME_COLS))
        begin
            cs = cs - CURSOR_W'(FRAME_COLS);
        end
    end

    assign read_ok = is_read && (rs < CURSOR_W'(FRAME_ROWS)) &&
                     (cs < CURSOR_W'(FRAME_COLS));
    assign rs_prod = RECIP_PROD_W'(rs) * RECIP_PROD_W'(RECIP);
    assign rs_line = rs_prod[RECIP_SHIFT +: CURSOR_W];
    assign rs_sub  = rs - (rs_line * CURSOR_W'(GLYPH_SIZE));

    assign frame_rd_addr = is_read ? LA'(rs_line) : LA'(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            opaque_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_draw_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_draw_reg <= draw_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_ok_reg <= read_ok;
            s1_line_reg    <= frame_rd_addr;
            s1_sub_reg     <= SW'(rs_sub);
            s1_col_reg     <= CW'(cs);
            s1_col0_reg    <= col_reg;
            s1_row_out_reg <= row_next;
            s1_col_out_reg <= col_next;
            s1_status_reg  <= put_bad;
        end
    end

    tgfw_store #(
        .DEPTH (GLYPH_COUNT),
        .WIDTH (PATTERN_W),
        .AW    (GA)
    ) u_glyphs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (GA'(glyph_index)),
        .wr_data (glyph_pattern),
        .rd_en   (accept),
        .rd_addr (GA'(char_code[CODE_W-2:0])),
        .rd_data (glyph_rd_data)
    );

    tgfw_store #(
        .DEPTH (LINES),
        .WIDTH (LINE_W),
        .AW    (LA)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_advance && s1_draw_reg),
        .wr_addr (s1_line_reg),
        .wr_data (frame_wr_data),
        .rd_en   (accept),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_data)
    );

    tgfw_line_edit #(
        .GLYPH_SIZE (GLYPH_SIZE),
        .FRAME_COLS (FRAME_COLS),
        .SW         (SW),
        .CW         (CW)
    ) u_edit (
        .line_word (frame_rd_data),
        .pattern   (glyph_rd_data),
        .col0      (s1_col0_reg),
        .opaque    (opaque_reg),
        .sub       (s1_sub_reg),
        .col       (s1_col_reg),
        .line_next (frame_wr_data),
        .cell_rd   (edit_cell)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            cell_code_reg  <= s1_read_ok_reg ? edit_cell : CELL_NONE;
            cursor_row_reg <= s1_row_out_reg;
            cursor_col_reg <= s1_col_out_reg;
            status_reg     <= s1_status_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign cell_code  = cell_code_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign status     = status_reg;

endmodule
